// ----- rtl/tdp_pkg.sv -----
package tdp_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int CNT_W       = $clog2(VALUE_WIDTH);
	localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 8;

	typedef logic [VALUE_WIDTH-1:0] value_t;

	// Request from the sequencer to the serial divider.
	typedef struct packed {
		logic start;
	} div_ctl_t;

	// Divider status; done is a one-cycle pulse with quotient and remainder valid.
	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ----- rtl/tdp_divider.sv -----
module tdp_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  tdp_pkg::div_ctl_t ctl,
	output tdp_pkg::div_sts_t sts,
	input  tdp_pkg::value_t   dividend,
	input  tdp_pkg::value_t   divisor,
	output tdp_pkg::value_t   quotient,
	output tdp_pkg::value_t   remainder
);

	localparam logic [tdp_pkg::CNT_W-1:0] CNT_LAST =
		tdp_pkg::CNT_W'(tdp_pkg::VALUE_WIDTH - 1);

	tdp_pkg::value_t                 rem_q;
	tdp_pkg::value_t                 quo_q;
	tdp_pkg::value_t                 dvs_q;
	logic [tdp_pkg::CNT_W-1:0]       cnt_q;
	logic                            busy_q;
	logic                            done_q;
	logic [tdp_pkg::VALUE_WIDTH:0]   trial;
	logic [tdp_pkg::VALUE_WIDTH:0]   diff;

	// One quotient bit per cycle: shift the next dividend bit into the partial
	// remainder and subtract the divisor if it fits.
	assign trial = {rem_q, quo_q[tdp_pkg::VALUE_WIDTH-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_LAST;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start && !busy_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[tdp_pkg::VALUE_WIDTH]) begin
				rem_q <= diff[tdp_pkg::VALUE_WIDTH-1:0];
				quo_q <= {quo_q[tdp_pkg::VALUE_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= trial[tdp_pkg::VALUE_WIDTH-1:0];
				quo_q <= {quo_q[tdp_pkg::VALUE_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- rtl/trial_division_prime_test_top.sv -----
// Order: candidates 0 and 1 go from the input beat straight to the finish state; otherwise
// each trial divisor runs a start state and a full division; divisors go from 2 up to the
// smallest factor or up to floor(sqrt(candidate)) + 1.
// Throughput: one candidate at a time; the next input beat is taken once the result has
// moved into the output register. The bit-serial divider (one quotient bit per cycle) sets it.
// Reset: arst_n clears the sequencer and the output valid at once; no clearing pass.
module trial_division_prime_test_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tdp_pkg::IN_TDATA_W-1:0] s_tdata,  // [VALUE_WIDTH-1:0] candidate
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tdp_pkg::OUT_TDATA_W-1:0] m_tdata  // [0] is_prime
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_START = 4'b0010,
		S_DIV   = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	state_t            state_q;
	tdp_pkg::value_t   n_q;
	tdp_pkg::value_t   d_q;
	logic              res_q;
	logic              m_valid_q;
	logic              prime_q;
	tdp_pkg::div_ctl_t ctl;
	tdp_pkg::div_sts_t sts;
	tdp_pkg::value_t   quo;
	tdp_pkg::value_t   rem;
	tdp_pkg::value_t   cand;
	logic              in_beat;
	logic              out_free;

	assign cand     = s_tdata[tdp_pkg::VALUE_WIDTH-1:0];
	assign s_tready = (state_q == S_IDLE);
	assign in_beat  = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign ctl.start = (state_q == S_START);

	tdp_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.dividend  (n_q),
		.divisor   (d_q),
		.quotient  (quo),
		.remainder (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						state_q <= (cand < tdp_pkg::VALUE_WIDTH'(2)) ? S_FIN : S_START;
					end
				end
				S_START: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					// The bound d*d <= n is checked as d <= n / d using the quotient.
					if (sts.done) begin
						if (d_q > quo || rem == '0) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_START;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			n_q   <= cand;
			d_q   <= tdp_pkg::VALUE_WIDTH'(2);
			res_q <= 1'b0;
		end else if (state_q == S_DIV && sts.done) begin
			if (d_q > quo) begin
				res_q <= 1'b1;
			end else if (rem == '0) begin
				res_q <= 1'b0;
			end else begin
				d_q <= d_q + tdp_pkg::VALUE_WIDTH'(1);
			end
		end
		if (state_q == S_FIN && out_free) begin
			prime_q <= res_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(tdp_pkg::OUT_TDATA_W-1){1'b0}}, prime_q};

	a_small_not_prime: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && cand < tdp_pkg::VALUE_WIDTH'(2)) |=> (state_q == S_FIN && !res_q))
		else $error("candidate below two not routed to a not-prime result");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	a_divisor_min: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (d_q >= tdp_pkg::VALUE_WIDTH'(2)))
		else $error("trial divisor below two");

	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == S_FIN))
		else $error("output beat raised without a finished test");

endmodule

// ----- tb/tb_trial_division_prime_test_top.sv -----
class prime_verdict_book;
	bit verdicts_due[$];
	int failures;

	function bit is_prime_by_trial(tdp_pkg::value_t cand);
		longint unsigned n;
		longint unsigned d;
		n = cand;
		if (n < 2)
			return 1'b0;
		// The bound is inclusive, so squares of primes are caught as composite.
		for (d = 2; d * d <= n; d++)
			if (n % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	function void note_candidate(tdp_pkg::value_t cand);
		verdicts_due.push_back(is_prime_by_trial(cand));
	endfunction

	function void check_verdict(bit got);
		bit want;
		if (verdicts_due.size() == 0) begin
			if (failures < 10)
				$display("output beat with no candidate pending: is_prime=%0d", got);
			failures++;
			return;
		end
		want = verdicts_due.pop_front();
		if (got !== want) begin
			if (failures < 10)
				$display("is_prime mismatch: expected %0d, got %0d", want, got);
			failures++;
		end
	endfunction

	function int pending();
		return verdicts_due.size();
	endfunction
endclass

module tb_trial_division_prime_test_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 4_000_000;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [tdp_pkg::IN_TDATA_W-1:0]  s_tdata;   // [VALUE_WIDTH-1:0] candidate
	logic                            m_tvalid;
	logic                            m_tready;
	logic [tdp_pkg::OUT_TDATA_W-1:0] m_tdata;   // [0] is_prime

	prime_verdict_book book = new();

	bit sender_burst;
	bit receiver_quiet;
	int hold_left;
	int cycles;

	trial_division_prime_test_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_trial_division_prime_test_top: done, errors");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			book.check_verdict(m_tdata[0]);
	end

	// Output side: a random stall after each beat unless quiet, and a long hold-off on request.
	initial begin
		int wait_left;
		wait_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (m_tready && m_tvalid) begin
				wait_left = receiver_quiet ? 0 : $urandom_range(0, 11);
				if (wait_left > 0)
					m_tready <= 1'b0;
			end else if (!m_tready) begin
				if (wait_left > 0)
					wait_left--;
				if (wait_left == 0)
					m_tready <= 1'b1;
			end
		end
	end

	task automatic send_candidate(tdp_pkg::value_t cand);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= tdp_pkg::IN_TDATA_W'(cand);
		do @(posedge clk); while (!s_tready);
		book.note_candidate(cand);
	endtask

	task automatic wait_for_verdicts();
		while (book.pending() != 0)
			@(posedge clk);
	endtask

	// Mostly small numbers, since a large prime needs a trial division for every divisor up to its square root.
	// Large values are built with a small factor so they finish quickly.
	function automatic tdp_pkg::value_t random_candidate();
		int unsigned pick;
		int unsigned p;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return $urandom_range(0, 1023);
		if (pick < 80)
			return $urandom_range(0, 65535);
		if (pick < 92) begin
			case ($urandom_range(0, 4))
				0: p = 3;
				1: p = 5;
				2: p = 7;
				3: p = 11;
				default: p = 13;
			endcase
			return tdp_pkg::value_t'(p * $urandom_range(1, 32'hFFFF_FFFF / p));
		end
		return tdp_pkg::value_t'({$urandom() >> 1, 1'b0});
	endfunction

	initial begin
		tdp_pkg::value_t directed_set[$];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		sender_burst = 1'b0;
		receiver_quiet = 1'b0;
		hold_left = 0;

		directed_set = '{
			32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd9, 32'd15,
			32'd25, 32'd49, 32'd97, 32'd121, 32'd63001, 32'd65521, 32'd65537,
			32'd1048573, 32'd1048576, 32'hFFFF_FFFF, 32'h8000_0000,
			32'hFFFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_set[i]) begin
			// Back the output up so the block holds a result and stops taking input.
			if (i == 5)
				hold_left = 400;
			send_candidate(directed_set[i]);
		end

		s_tvalid <= 1'b0;
		wait_for_verdicts();
		@(posedge clk);

		for (int phase = 0; phase < 4; phase++) begin
			sender_burst = (phase == 1) || (phase == 3);
			receiver_quiet = (phase == 2) || (phase == 3);
			repeat (20) send_candidate(random_candidate());
		end

		s_tvalid <= 1'b0;
		wait_for_verdicts();
		repeat (40) @(posedge clk);

		if (book.failures == 0 && book.pending() == 0)
			$display("tb_trial_division_prime_test_top: done, clean");
		else
			$display("tb_trial_division_prime_test_top: done, errors");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/tdp_pkg.sv
rtl/tdp_divider.sv
rtl/trial_division_prime_test_top.sv
tb/tb_trial_division_prime_test_top.sv
